FILE: rtl/core/whfm_pkg.sv
// Package for the window high-fraction mask: register map, reset values,
// configuration and cell control types. No dependencies.
package whfm_pkg;

  localparam int unsigned MaxWindowDef = 64;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_WINDOW_LEN     = 2'd0,
    REG_HIGH_THRESHOLD = 2'd1,
    REG_HIGH_FRACTION  = 2'd2
  } reg_idx_e;

  localparam logic [6:0]         WindowLenRst     = 7'd8;
  localparam logic signed [15:0] HighThresholdRst = 16'sd16382;
  localparam logic [8:0]         HighFractionRst  = 9'd128;

  typedef struct packed {
    logic [6:0]         window_len;
    logic signed [15:0] high_threshold;
    logic [8:0]         high_fraction;
  } cfg_t;

  // Broadcast to every cell of the count chain
  typedef struct packed {
    logic en;     // item accepted: advance the chain
    logic clear;  // first gate of a radial: restart all counts
    logic flag;   // high flag of the accepted item
  } cell_ctl_t;

endpackage

FILE: rtl/core/window_high_fraction_mask.sv
// Top level of the window high-fraction mask: count chain, mask decision,
// two-entry output stage. Depends on whfm_pkg, whfm_cell, whfm_regs.
//
//  channel  | dir | payload
//  ---------+-----+-------------------------------------------------------
//  s_axis   | in  | tdata[15:0] cc_sample; tuser[0] sample_valid,
//           |     | tuser[1] radial_start
//  m_axis   | out | tdata[0] keep_flag, tdata[7:1] zero
//  apb      | in  | 0x0 window_len, 0x4 high_threshold, 0x8 high_fraction
//
// One item per cycle while tready is high; each result is registered. Cell i
// of the chain holds the high count of the last i+1 gates, so any window
// length is read from one cell with no recount. Reset clears all counts, the
// fill count and the output stage at once. On an output stall up to two
// results are held; tready drops when both are.
module window_high_fraction_mask #(
  parameter int unsigned MAX_WINDOW = whfm_pkg::MaxWindowDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,   // [15:0] cc_sample
  input  logic [1:0]                  s_axis_tuser,   // [0] sample_valid, [1] radial_start
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [0] keep_flag, [7:1] zero
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [whfm_pkg::AddrW-1:0]  paddr,
  input  logic [whfm_pkg::DataW-1:0]  pwdata,
  output logic [whfm_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import whfm_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IdxW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned ProdW = CntW + 9;

  cfg_t cfg;

  whfm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic               acc;
  logic signed [15:0] sample;
  logic               valid, start;
  cell_ctl_t          ctl;

  assign acc    = s_axis_tvalid && s_axis_tready;
  assign sample = s_axis_tdata;
  assign valid  = s_axis_tuser[0];
  assign start  = s_axis_tuser[1];

  assign ctl.en    = acc;
  assign ctl.clear = start;
  assign ctl.flag  = valid && (sample > cfg.high_threshold);

  // Count chain
  logic [CntW-1:0] cnt_q   [MAX_WINDOW];
  logic [CntW-1:0] cnt_nxt [MAX_WINDOW];

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [CntW-1:0] prev;
    if (i == 0) begin : g_head
      assign prev = '0;
    end else begin : g_link
      assign prev = cnt_q[i-1];
    end
    whfm_cell #(.CntW(CntW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .prev_cnt_i (prev),
      .cnt_o      (cnt_q[i]),
      .cnt_nxt_o  (cnt_nxt[i])
    );
  end

  // Gates seen in this radial, saturating at the deepest window
  logic [CntW-1:0] fill_q, fill_d;

  always_comb begin
    if (start) begin
      fill_d = CntW'(1);
    end else if (32'(fill_q) < MAX_WINDOW) begin
      fill_d = fill_q + CntW'(1);
    end else begin
      fill_d = fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (acc) begin
      fill_q <= fill_d;
    end
  end

  // Mask decision
  logic [CntW-1:0]  win_n, win_nm1;
  logic [CntW-1:0]  win_cnt;
  logic [ProdW-1:0] cnt_scaled, frac_scaled;
  logic             keep;

  assign win_n = (32'(cfg.window_len) > MAX_WINDOW) ? CntW'(MAX_WINDOW)
                                                    : CntW'(cfg.window_len);
  assign win_nm1     = win_n - CntW'(1);
  assign win_cnt     = cnt_nxt[win_nm1[IdxW-1:0]];
  assign cnt_scaled  = ProdW'({win_cnt, 8'h00});
  assign frac_scaled = ProdW'(cfg.high_fraction) * ProdW'(win_n);

  assign keep = !((win_n != '0) && valid && (fill_d >= win_n) &&
                  (cnt_scaled > frac_scaled));

  // Output register and skid entry
  logic out_v_q, out_q, skid_v_q, skid_q;
  logic take;

  assign take          = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !skid_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'b0, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || take) begin
      // advance: skid entry first, else the fresh result
      out_v_q  <= skid_v_q || acc;
      skid_v_q <= 1'b0;
    end else if (acc) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || take) begin
      out_q <= skid_v_q ? skid_q : keep;
    end
    if (out_v_q && !take && acc) begin
      skid_q <= keep;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without an output result");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_v_q)
    else $error("accepted item left no result");

  a_start_restarts_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && start) |=> (fill_q == CntW'(1)))
    else $error("fill count not restarted at radial start");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= MAX_WINDOW)
    else $error("fill count beyond deepest window");

  a_head_cell_one_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= CntW'(1))
    else $error("first cell counts more than one gate");

endmodule

FILE: rtl/core/whfm_cell.sv
// One cell of the count chain: holds the number of high flags among the
// most recent (index+1) gates. Depends on whfm_pkg.
module whfm_cell #(
  parameter int unsigned CntW = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  whfm_pkg::cell_ctl_t   ctl_i,
  input  logic [CntW-1:0]       prev_cnt_i,  // neighbour's count, one gate shorter
  output logic [CntW-1:0]       cnt_o,
  output logic [CntW-1:0]       cnt_nxt_o
);
  import whfm_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;

  // The window one gate longer ends with the new flag
  always_comb begin
    if (ctl_i.clear) begin
      cnt_d = CntW'(ctl_i.flag);
    end else begin
      cnt_d = prev_cnt_i + CntW'(ctl_i.flag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.en) begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o     = cnt_q;
  assign cnt_nxt_o = cnt_d;

endmodule

FILE: rtl/core/whfm_regs.sv
// APB register bank: window length, high threshold, high fraction.
// Depends on whfm_pkg.
module whfm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [whfm_pkg::AddrW-1:0]    paddr,
  input  logic [whfm_pkg::DataW-1:0]    pwdata,
  output logic [whfm_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output whfm_pkg::cfg_t                cfg_o
);
  import whfm_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len     <= WindowLenRst;
      cfg_q.high_threshold <= HighThresholdRst;
      cfg_q.high_fraction  <= HighFractionRst;
    end else if (wr_en) begin
      case (idx)
        REG_WINDOW_LEN:     cfg_q.window_len     <= pwdata[6:0];
        REG_HIGH_THRESHOLD: cfg_q.high_threshold <= pwdata[15:0];
        REG_HIGH_FRACTION:  cfg_q.high_fraction  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WINDOW_LEN:     prdata = DataW'(cfg_q.window_len);
      REG_HIGH_THRESHOLD: prdata = DataW'(cfg_q.high_threshold);
      REG_HIGH_FRACTION:  prdata = DataW'(cfg_q.high_fraction);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
